/* rtl/core/battery_cell_fault_monitor_assert.svh */
// ----------------------------------------------------------------------------
// battery cell fault monitor assertion macros
// concurrent checks that vanish when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef BATTERY_CELL_FAULT_MONITOR_ASSERT_SVH
`define BATTERY_CELL_FAULT_MONITOR_ASSERT_SVH

`ifndef ASSERT_OFF
// expression holds at every clock edge out of reset
`define BCFM_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: check failed");
// consequent holds in the same cycle as the antecedent
`define BCFM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
// consequent holds in the cycle after the antecedent
`define BCFM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define BCFM_ASSERT(label, clk, rst_n, expr)
`define BCFM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BCFM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/bcfm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcfm_pkg
// widths, codes and reset values of the battery cell fault monitor
// ----------------------------------------------------------------------------
package bcfm_pkg;

    localparam int VOLT_W   = 13;
    localparam int TEMP_W   = 12;
    localparam int CURR_W   = 24;
    localparam int LIMIT_W  = 23;
    localparam int FAULT_W  = 5;
    localparam int CFG_W    = 23;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [1:0] {
        ACT_CELL    = 2'd0,
        ACT_CURRENT = 2'd1,
        ACT_CLEAR   = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    localparam logic [CFG_IDX_W-1:0] CFG_OVER_VOLTAGE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNDER_VOLTAGE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OVER_TEMP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OVER_CURRENT  = 3'd4;

    localparam int FLT_OV    = 0;
    localparam int FLT_UV    = 1;
    localparam int FLT_OT    = 2;
    localparam int FLT_DELTA = 3;
    localparam int FLT_OC    = 4;

    localparam logic [VOLT_W-1:0]        RST_OVER_VOLTAGE  = 13'd4200;
    localparam logic [VOLT_W-1:0]        RST_UNDER_VOLTAGE = 13'd2800;
    localparam logic signed [TEMP_W-1:0] RST_OVER_TEMP     = 12'sd600;
    localparam logic [VOLT_W-1:0]        RST_DELTA_LIMIT   = 13'd200;
    localparam logic [LIMIT_W-1:0]       RST_OVER_CURRENT  = 23'd300000;

    typedef struct packed {
        logic               sdc_closed;
        logic [FAULT_W-1:0] latched_faults;
        logic [FAULT_W-1:0] active_faults;
    } t_result;

endpackage
`default_nettype wire

/* rtl/core/battery_cell_fault_monitor.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// battery_cell_fault_monitor
// per-cell limit checks, pack spread and current checks, latched faults
// ----------------------------------------------------------------------------
// Items enter on the s_axis channel: tuser carries the action (cell sample,
// current update, clear request), tlast marks the last cell of a scan, and
// tdata carries the cell voltage, cell temperature and raw pack current.
// One result leaves on m_axis for every last cell sample; other items give
// no result. Thresholds are written through the i_cfg port; the user is to
// write them only while idle; the block does not enforce it. An item is
// registered on entry in the input register and evaluated from there; a
// last cell sample's result goes into the result register, which drives
// m_axis. One item per cycle is sustained while no result waits untaken: the
// input and result registers each hold one item and move together.
// When the receiver holds m_axis_tready low with a result waiting, the
// input register fills and s_axis_tready drops until the result is taken.
// Synchronous reset loads the default thresholds, clears the latched faults
// and pending clear, zeroes the stored current and arms a new scan.
// ----------------------------------------------------------------------------
module battery_cell_fault_monitor
    import bcfm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_W-1:0]      i_cfg_wdata,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [12:0] cell_voltage, [24:13] cell_temp, [48:25] current_raw, [55:49] zero
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] action
    input  wire logic [1:0]            s_axis_tuser,
    input  wire logic                  s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [4:0] active_faults, [9:5] latched_faults, [10] sdc_closed, [15:11] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    // configuration
    logic [VOLT_W-1:0]        r_over_voltage;
    logic [VOLT_W-1:0]        r_under_voltage;
    logic signed [TEMP_W-1:0] r_over_temp;
    logic [VOLT_W-1:0]        r_delta_limit;
    logic [LIMIT_W-1:0]       r_over_current;

    // input register
    logic                     r_in_valid;
    t_action                  r_action;
    logic [VOLT_W-1:0]        r_volt;
    logic signed [TEMP_W-1:0] r_temp;
    logic                     r_last;
    logic signed [CURR_W-1:0] r_curr_raw;

    // scan state
    logic signed [CURR_W-1:0] r_pack_current;
    logic signed [CURR_W-1:0] r_scan_current;
    logic                     r_clear_pending;
    logic [FAULT_W-1:0]       r_fault_latch;
    logic [2:0]               r_scan_faults;
    logic [VOLT_W-1:0]        r_max_volt;
    logic [VOLT_W-1:0]        r_min_volt;
    logic                     r_scan_start;

    // result register
    logic                     r_out_valid;
    t_result                  r_out;

    logic                     out_free;
    logic                     advance;
    logic                     is_cell;
    logic                     is_end;
    logic signed [CURR_W-1:0] n_scan_current;
    logic [2:0]               n_scan_faults;
    logic [VOLT_W-1:0]        n_max_volt;
    logic [VOLT_W-1:0]        n_min_volt;
    logic [VOLT_W-1:0]        base_max;
    logic [VOLT_W-1:0]        base_min;
    logic [VOLT_W-1:0]        spread;
    logic signed [CURR_W:0]   cur_ext;
    logic signed [CURR_W:0]   lim_pos;
    logic signed [CURR_W:0]   lim_neg;
    logic [FAULT_W-1:0]       active;
    logic [FAULT_W-1:0]       n_fault_latch;
    t_result                  n_out;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    assign is_cell = (r_action == ACT_CELL);
    assign is_end  = is_cell && r_last;

    always_comb begin
        // a scan's first cell seeds min/max and snapshots the current
        base_max       = r_scan_start ? r_volt : r_max_volt;
        base_min       = r_scan_start ? r_volt : r_min_volt;
        n_scan_current = r_scan_start ? r_pack_current : r_scan_current;
        n_scan_faults  = r_scan_start ? 3'b000 : r_scan_faults;
        if (r_volt > r_over_voltage) begin
            n_scan_faults[FLT_OV] = 1'b1;
        end
        if (r_volt < r_under_voltage) begin
            n_scan_faults[FLT_UV] = 1'b1;
        end
        if (r_temp > r_over_temp) begin
            n_scan_faults[FLT_OT] = 1'b1;
        end
        n_max_volt = (r_volt > base_max) ? r_volt : base_max;
        n_min_volt = (r_volt < base_min) ? r_volt : base_min;
        spread     = n_max_volt - n_min_volt;

        cur_ext = {n_scan_current[CURR_W-1], n_scan_current};
        lim_pos = signed'({2'b00, r_over_current});
        lim_neg = -lim_pos;

        active            = {2'b00, n_scan_faults};
        active[FLT_DELTA] = (spread > r_delta_limit);
        active[FLT_OC]    = (cur_ext > lim_pos) || (cur_ext < lim_neg);

        // a pending clear keeps only what is still active
        n_fault_latch = r_clear_pending ? active : (r_fault_latch | active);

        n_out.active_faults  = active;
        n_out.latched_faults = n_fault_latch;
        n_out.sdc_closed     = (n_fault_latch == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_over_voltage  <= RST_OVER_VOLTAGE;
            r_under_voltage <= RST_UNDER_VOLTAGE;
            r_over_temp     <= RST_OVER_TEMP;
            r_delta_limit   <= RST_DELTA_LIMIT;
            r_over_current  <= RST_OVER_CURRENT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_OVER_VOLTAGE: begin
                    r_over_voltage <= i_cfg_wdata[VOLT_W-1:0];
                end
                CFG_UNDER_VOLTAGE: begin
                    r_under_voltage <= i_cfg_wdata[VOLT_W-1:0];
                end
                CFG_OVER_TEMP: begin
                    r_over_temp <= signed'(i_cfg_wdata[TEMP_W-1:0]);
                end
                CFG_DELTA_LIMIT: begin
                    r_delta_limit <= i_cfg_wdata[VOLT_W-1:0];
                end
                CFG_OVER_CURRENT: begin
                    r_over_current <= i_cfg_wdata[LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_action   <= t_action'(s_axis_tuser);
            r_volt     <= s_axis_tdata[12:0];
            r_temp     <= signed'(s_axis_tdata[24:13]);
            r_curr_raw <= signed'(s_axis_tdata[48:25]);
            r_last     <= s_axis_tlast;
        end
    end

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pack_current  <= '0;
            r_scan_current  <= '0;
            r_clear_pending <= 1'b0;
            r_fault_latch   <= '0;
            r_scan_faults   <= '0;
            r_max_volt      <= '0;
            r_min_volt      <= '0;
            r_scan_start    <= 1'b1;
        end else if (advance) begin
            case (r_action)
                ACT_CURRENT: begin
                    r_pack_current <= r_curr_raw;
                end
                ACT_CLEAR: begin
                    r_clear_pending <= 1'b1;
                end
                ACT_CELL: begin
                    r_scan_current <= n_scan_current;
                    r_scan_faults  <= n_scan_faults;
                    r_max_volt     <= n_max_volt;
                    r_min_volt     <= n_min_volt;
                    r_scan_start   <= r_last;
                    if (r_last) begin
                        r_fault_latch   <= n_fault_latch;
                        r_clear_pending <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && is_end) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && is_end) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - 2*FAULT_W - 1){1'b0}}, r_out};

`include "battery_cell_fault_monitor_assert.svh"

    `BCFM_ASSERT_IMP(a_sdc_matches_latch, i_clk, i_rst_n, r_out_valid, r_out.sdc_closed == (r_out.latched_faults == '0))
    `BCFM_ASSERT_IMP(a_active_in_latch, i_clk, i_rst_n, r_out_valid, (r_out.active_faults & ~r_out.latched_faults) == '0)
    `BCFM_ASSERT_IMP(a_min_below_max, i_clk, i_rst_n, !r_scan_start, r_min_volt <= r_max_volt)
    `BCFM_ASSERT_NXT(a_clear_consumed, i_clk, i_rst_n, advance && is_end, !r_clear_pending && r_scan_start)
    `BCFM_ASSERT_IMP(a_stall_only_when_full, i_clk, i_rst_n, !s_axis_tready, r_in_valid && r_out_valid)

endmodule
`default_nettype wire
